/* hw/rtl/srmq_pkg.sv */
// shared types and constants for the sortable ring message queue
package srmq_pkg;

	localparam int DefDepth     = 16;
	localparam int DefDataWidth = 32;

	// request codes on the operation field; code 3 is unused
	typedef enum logic [1:0] {
		OpPost  = 2'd0,
		OpFetch = 2'd1,
		OpSort  = 2'd2
	} op_t;

	// configuration register indexes
	localparam logic CfgCapacity = 1'b0;
	localparam logic CfgSortDesc = 1'b1;

endpackage

/* hw/rtl/srmq_ram.sv */
// simple dual-port synchronous ram, one write and one registered read port
module srmq_ram #(
	parameter int DEPTH = srmq_pkg::DefDepth,
	parameter int WIDTH = srmq_pkg::DefDataWidth
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hw/rtl/sortable_ring_message_queue.sv */
// top level: ring message queue with in-place sort sequencer
// - request channel (in_valid/in_ready): operation and payload; operation 0 posts
//   a word, 1 fetches the oldest word, 2 sorts all held words, 3 does nothing
// - result channel (out_valid/out_ready): exactly one result per request: status
//   (1 = full on post), fetched_valid, fetched_data and the count after the request
// - config channel (cfg_valid/cfg_ready, always ready): capacity (index 0) and
//   sort_descending (index 1); write only while no request is in flight
// - post, empty fetch, empty sort and unused code: result registered at the accept
//   edge, so one request every cycle while the receiver keeps up
// - fetch: result registered in the cycle after the accept, from the slot ram read data
// - sort of n words: gather them into the scratch ram, insert each word i (read
//   and load it, then a read and a compare per step), end the scan, copy the
//   words back, wrap the write index modulo the capacity and register the result
// - reset clears indexes, count and result, capacity goes to DEPTH, ascending;
//   slot contents are undefined until written and need no clearing pass
// - a stalled result waits in the output register; no new request is accepted
//   until it is taken, or taken in the same cycle
module sortable_ring_message_queue #(
	parameter int DEPTH      = srmq_pkg::DefDepth,
	parameter int DATA_WIDTH = srmq_pkg::DefDataWidth
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 operation,
	input  logic [DATA_WIDTH-1:0]      payload,
	// result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       status,
	output logic                       fetched_valid,
	output logic [DATA_WIDTH-1:0]      fetched_data,
	output logic [$clog2(DEPTH):0]     message_count,
	// config write channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [$clog2(DEPTH):0]     cfg_data
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] DepthC = CW'(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_FETCH, S_G_RD, S_G_WR, S_I_RDV, S_I_LDV, S_I_RD, S_I_CMP,
		S_C_RD, S_C_WR, S_MOD, S_DONE
	} state_t;

	state_t state_q;

	logic [IW-1:0]         rd_idx_q, wr_idx_q;
	logic [CW-1:0]         count_q, cap_q;
	logic                  desc_q;
	logic [CW-1:0]         i_q, j_q, k_q;
	logic [DATA_WIDTH-1:0] v_q;

	logic                  out_valid_q, status_q, fvalid_q;
	logic [DATA_WIDTH-1:0] fdata_q;
	logic [CW-1:0]         ocount_q;

	// slot ram and scratch ram ports
	logic                  m_wr_en, m_rd_en, s_wr_en, s_rd_en;
	logic [IW-1:0]         m_wr_addr, s_wr_addr, s_rd_addr;
	logic [DATA_WIDTH-1:0] m_wr_data, s_wr_data, m_rd_data, s_rd_data;

	logic          in_fire, out_free, full, empty, ooo;
	logic [CW-1:0] cap_eff, rd_inc, wr_inc;
	logic [IW-1:0] rd_adv, wr_adv;
	srmq_pkg::op_t op;

	assign op       = srmq_pkg::op_t'(operation);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign in_fire  = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// capacity of zero acts as one, above depth acts as depth
	assign cap_eff = (cap_q == '0) ? CW'(1) : ((cap_q > DepthC) ? DepthC : cap_q);
	assign full    = count_q >= cap_eff;
	assign empty   = count_q == '0;

	// index advance wraps at the effective capacity
	assign rd_inc = CW'(rd_idx_q) + CW'(1);
	assign wr_inc = CW'(wr_idx_q) + CW'(1);
	assign rd_adv = (rd_inc >= cap_eff) ? '0 : rd_inc[IW-1:0];
	assign wr_adv = (wr_inc >= cap_eff) ? '0 : wr_inc[IW-1:0];

	// compare of scratch word against the held insert value
	assign ooo = desc_q ? (s_rd_data < v_q) : (s_rd_data > v_q);

	// memory request steering
	always_comb begin
		m_wr_en   = 1'b0;
		m_wr_addr = wr_idx_q;
		m_wr_data = payload;
		m_rd_en   = 1'b0;
		s_wr_en   = 1'b0;
		s_wr_addr = i_q[IW-1:0];
		s_wr_data = m_rd_data;
		s_rd_en   = 1'b0;
		s_rd_addr = i_q[IW-1:0];
		if (in_fire && op == srmq_pkg::OpPost && !full) begin
			m_wr_en = 1'b1;
		end
		if (in_fire && op == srmq_pkg::OpFetch && !empty) begin
			m_rd_en = 1'b1;
		end
		unique case (state_q)
			S_G_RD: m_rd_en = 1'b1;
			S_G_WR: s_wr_en = 1'b1;
			S_I_RDV: s_rd_en = i_q < count_q;
			S_I_RD: begin
				if (j_q == '0) begin
					s_wr_en   = 1'b1;
					s_wr_addr = '0;
					s_wr_data = v_q;
				end else begin
					s_rd_en   = 1'b1;
					s_rd_addr = IW'(j_q - CW'(1));
				end
			end
			S_I_CMP: begin
				s_wr_en   = 1'b1;
				s_wr_addr = j_q[IW-1:0];
				s_wr_data = ooo ? s_rd_data : v_q;
			end
			S_C_RD: begin
				s_rd_en   = 1'b1;
				s_rd_addr = k_q[IW-1:0];
			end
			S_C_WR: begin
				m_wr_en   = 1'b1;
				m_wr_addr = k_q[IW-1:0];
				m_wr_data = s_rd_data;
			end
			default: ;
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= DepthC;
			desc_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				srmq_pkg::CfgCapacity: cap_q  <= cfg_data;
				srmq_pkg::CfgSortDesc: desc_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// request sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			count_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			v_q         <= '0;
			out_valid_q <= 1'b0;
			status_q    <= 1'b0;
			fvalid_q    <= 1'b0;
			fdata_q     <= '0;
			ocount_q    <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						status_q <= 1'b0;
						fvalid_q <= 1'b0;
						fdata_q  <= '0;
						ocount_q <= count_q;
						case (op)
							srmq_pkg::OpPost: begin
								out_valid_q <= 1'b1;
								if (full) begin
									status_q <= 1'b1;
								end else begin
									wr_idx_q <= wr_adv;
									ocount_q <= count_q + CW'(1);
									count_q  <= count_q + CW'(1);
								end
							end
							srmq_pkg::OpFetch: begin
								if (empty) begin
									out_valid_q <= 1'b1;
								end else begin
									rd_idx_q <= rd_adv;
									count_q  <= count_q - CW'(1);
									state_q  <= S_FETCH;
								end
							end
							srmq_pkg::OpSort: begin
								if (empty) begin
									out_valid_q <= 1'b1;
								end else begin
									i_q     <= '0;
									state_q <= S_G_RD;
								end
							end
							default: out_valid_q <= 1'b1;
						endcase
					end
				end
				S_FETCH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						fvalid_q    <= 1'b1;
						fdata_q     <= m_rd_data;
						ocount_q    <= count_q;
						state_q     <= S_IDLE;
					end
				end
				// gather held words from the ring into scratch slots 0..n-1
				S_G_RD: begin
					rd_idx_q <= rd_adv;
					state_q  <= S_G_WR;
				end
				S_G_WR: begin
					if (i_q + CW'(1) == count_q) begin
						i_q     <= CW'(1);
						state_q <= S_I_RDV;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_G_RD;
					end
				end
				// insertion sort in scratch, one access per step
				S_I_RDV: begin
					if (i_q < count_q) begin
						state_q <= S_I_LDV;
					end else begin
						k_q     <= '0;
						state_q <= S_C_RD;
					end
				end
				S_I_LDV: begin
					v_q     <= s_rd_data;
					j_q     <= i_q;
					state_q <= S_I_RD;
				end
				S_I_RD: begin
					if (j_q == '0) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_I_RDV;
					end else begin
						state_q <= S_I_CMP;
					end
				end
				S_I_CMP: begin
					if (ooo) begin
						j_q     <= j_q - CW'(1);
						state_q <= S_I_RD;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_I_RDV;
					end
				end
				// copy sorted words back to ring slots 0..n-1
				S_C_RD: state_q <= S_C_WR;
				S_C_WR: begin
					if (k_q + CW'(1) == count_q) begin
						rd_idx_q <= '0;
						k_q      <= count_q;
						state_q  <= S_MOD;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= S_C_RD;
					end
				end
				// write index is count modulo capacity
				S_MOD: begin
					if (k_q >= cap_eff) begin
						k_q <= k_q - cap_eff;
					end else begin
						wr_idx_q <= k_q[IW-1:0];
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= 1'b0;
						fvalid_q    <= 1'b0;
						fdata_q     <= '0;
						ocount_q    <= count_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	srmq_ram #(.DEPTH(DEPTH), .WIDTH(DATA_WIDTH)) u_slot_ram (
		.clk     (clk),
		.wr_en   (m_wr_en),
		.wr_addr (m_wr_addr),
		.wr_data (m_wr_data),
		.rd_en   (m_rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (m_rd_data)
	);

	srmq_ram #(.DEPTH(DEPTH), .WIDTH(DATA_WIDTH)) u_scratch_ram (
		.clk     (clk),
		.wr_en   (s_wr_en),
		.wr_addr (s_wr_addr),
		.wr_data (s_wr_data),
		.rd_en   (s_rd_en),
		.rd_addr (s_rd_addr),
		.rd_data (s_rd_data)
	);

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign fetched_valid = fvalid_q;
	assign fetched_data  = fdata_q;
	assign message_count = ocount_q;

	// held count never exceeds the ring depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DepthC)
		else $error("held count above depth");

	// a full post leaves the count unchanged
	a_full_post: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && op == srmq_pkg::OpPost && full |=> count_q == $past(count_q))
		else $error("full post changed count");

	// a result never flags both full and a fetched word
	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(status_q && fvalid_q))
		else $error("full status with fetched word");

	// a sort leaves the read index at zero
	a_sort_ridx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> rd_idx_q == '0)
		else $error("read index not reset by sort");

	// slot ram is never written in the gather write, scan read or scan compare states
	a_no_wr_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_I_RD || state_q == S_I_CMP || state_q == S_G_WR) |-> !m_wr_en)
		else $error("slot write during sort scan");

endmodule

/* verif/sortable_ring_message_queue_tb.sv */
// testbench for the sortable ring message queue: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module sortable_ring_message_queue_tb;

	localparam int Depth   = 16;
	localparam int DataW   = 32;
	localparam int CountW  = $clog2(Depth) + 1;
	localparam logic [1:0] OpUnused = 2'd3;

	typedef struct packed {
		logic [1:0]       op;
		logic [DataW-1:0] data;
	} request_t;

	typedef struct packed {
		logic              status;
		logic              valid;
		logic [DataW-1:0]  data;
		logic [CountW-1:0] count;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] operation = 2'd0;
	logic [DataW-1:0] payload = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic status;
	logic fetched_valid;
	logic [DataW-1:0] fetched_data;
	logic [CountW-1:0] message_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [CountW-1:0] cfg_data = '0;

	// request queue filled by the stimulus block, answers predicted at accept time
	request_t pending_reqs[$];
	answer_t  expected_answers[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit failed = 1'b0;

	// shadow of the queue state and its registers
	logic [DataW-1:0]  shadow_slots[Depth];
	int unsigned       shadow_rd;
	int unsigned       shadow_wr;
	int unsigned       shadow_held;
	logic [CountW-1:0] shadow_cap_reg;
	logic              shadow_desc;

	sortable_ring_message_queue #(.DEPTH(Depth), .DATA_WIDTH(DataW)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .payload(payload),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .fetched_valid(fetched_valid),
		.fetched_data(fetched_data), .message_count(message_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// capacity register clamped to 1..Depth
	function automatic int unsigned usable_slots();
		if (shadow_cap_reg == 0) return 1;
		if (shadow_cap_reg > Depth) return Depth;
		return shadow_cap_reg;
	endfunction

	function automatic int unsigned ring_next(int unsigned idx, int unsigned cap);
		return (idx + 1 >= cap) ? 0 : idx + 1;
	endfunction

	// apply one request to the shadow state and return the answer it should give
	function automatic answer_t queue_answer(request_t req);
		answer_t ans;
		int unsigned cap;
		int unsigned idx;
		logic [DataW-1:0] gathered[Depth];
		logic [DataW-1:0] held_word;
		int k;
		cap = usable_slots();
		ans = '0;
		case (req.op)
			srmq_pkg::OpPost: begin
				if (shadow_held >= cap) begin
					ans.status = 1'b1;
				end else begin
					shadow_slots[shadow_wr] = req.data;
					shadow_wr = ring_next(shadow_wr, cap);
					shadow_held++;
				end
			end
			srmq_pkg::OpFetch: begin
				if (shadow_held != 0) begin
					ans.valid = 1'b1;
					ans.data = shadow_slots[shadow_rd];
					shadow_rd = ring_next(shadow_rd, cap);
					shadow_held--;
				end
			end
			srmq_pkg::OpSort: begin
				if (shadow_held != 0) begin
					// gather oldest first, then insertion sort
					idx = shadow_rd;
					for (int i = 0; i < shadow_held; i++) begin
						gathered[i] = shadow_slots[idx];
						idx = ring_next(idx, cap);
					end
					for (int i = 1; i < shadow_held; i++) begin
						held_word = gathered[i];
						k = i;
						while (k > 0 && (shadow_desc ? (gathered[k-1] < held_word)
								: (gathered[k-1] > held_word))) begin
							gathered[k] = gathered[k-1];
							k--;
						end
						gathered[k] = held_word;
					end
					for (int i = 0; i < shadow_held; i++) shadow_slots[i] = gathered[i];
					shadow_rd = 0;
					shadow_wr = shadow_held % cap;
				end
			end
			default: ;
		endcase
		ans.count = shadow_held[CountW-1:0];
		return ans;
	endfunction

	// request driver: predicts on every accepted request, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_answers.push_back(queue_answer('{operation, payload}));
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					request_t req;
					req = pending_reqs.pop_front();
					in_valid  <= 1'b1;
					operation <= req.op;
					payload   <= req.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compares each taken result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected result st=%0b v=%0b d=%h cnt=%0d", $time,
						status, fetched_valid, fetched_data, message_count);
					failed = 1'b1;
				end else begin
					answer_t exp_ans;
					exp_ans = expected_answers.pop_front();
					if (status !== exp_ans.status) begin
						$display("%0t: status expected %0b got %0b", $time,
							exp_ans.status, status);
						failed = 1'b1;
					end
					if (fetched_valid !== exp_ans.valid) begin
						$display("%0t: fetched_valid expected %0b got %0b", $time,
							exp_ans.valid, fetched_valid);
						failed = 1'b1;
					end
					if (fetched_data !== exp_ans.data) begin
						$display("%0t: fetched_data expected %h got %h", $time,
							exp_ans.data, fetched_data);
						failed = 1'b1;
					end
					if (message_count !== exp_ans.count) begin
						$display("%0t: message_count expected %0d got %0d", $time,
							exp_ans.count, message_count);
						failed = 1'b1;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic wait_quiet();
		while (pending_reqs.size() != 0 || in_valid || expected_answers.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CountW-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == srmq_pkg::CfgCapacity) shadow_cap_reg = value;
		else shadow_desc = value[0];
	endtask

	task automatic add_req(logic [1:0] op, logic [DataW-1:0] data);
		pending_reqs.push_back('{op, data});
	endtask

	// empty the queue so a new capacity never exposes unwritten slots
	task automatic drain_then_set_capacity(logic [CountW-1:0] value);
		wait_quiet();
		repeat (shadow_held) add_req(srmq_pkg::OpFetch, $urandom);
		wait_quiet();
		write_reg(srmq_pkg::CfgCapacity, value);
	endtask

	function automatic logic [DataW-1:0] pick_word();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return $urandom_range(7);
			default: return $urandom;
		endcase
	endfunction

	// random traffic in bursts that lean toward filling or toward emptying
	task automatic random_phase(int n);
		int post_pct;
		int roll;
		for (int i = 0; i < n; i++) begin
			if (i % 24 == 0) post_pct = $urandom_range(25, 80);
			roll = $urandom_range(99);
			if (roll < 4) add_req(srmq_pkg::OpSort, $urandom);
			else if (roll < 6) add_req(OpUnused, $urandom);
			else if (roll < 6 + post_pct * 94 / 100) add_req(srmq_pkg::OpPost, pick_word());
			else add_req(srmq_pkg::OpFetch, $urandom);
		end
	endtask

	initial begin
		shadow_rd = 0;
		shadow_wr = 0;
		shadow_held = 0;
		shadow_cap_reg = Depth;
		shadow_desc = 1'b0;
		foreach (shadow_slots[i]) shadow_slots[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, empty cases, full post, unused code, sorts
		write_reg(srmq_pkg::CfgCapacity, 5'd4);
		add_req(srmq_pkg::OpFetch, '1);
		add_req(srmq_pkg::OpSort, '0);
		add_req(OpUnused, '1);
		add_req(srmq_pkg::OpPost, 32'hFFFF_FFFF);
		add_req(srmq_pkg::OpPost, 32'h0000_0000);
		add_req(srmq_pkg::OpPost, 32'h8000_0001);
		add_req(srmq_pkg::OpFetch, '0);
		add_req(srmq_pkg::OpPost, 32'h0000_0005);
		add_req(srmq_pkg::OpPost, 32'h7FFF_FFFF);
		add_req(srmq_pkg::OpPost, 32'h1234_5678);
		add_req(srmq_pkg::OpSort, '1);
		add_req(srmq_pkg::OpFetch, '0);
		add_req(srmq_pkg::OpPost, 32'h0000_0003);
		add_req(srmq_pkg::OpPost, 32'h0000_0004);
		wait_quiet();
		write_reg(srmq_pkg::CfgSortDesc, 5'd1);
		add_req(srmq_pkg::OpSort, '0);
		add_req(srmq_pkg::OpFetch, '0);
		add_req(srmq_pkg::OpFetch, '0);
		add_req(srmq_pkg::OpFetch, '0);
		add_req(srmq_pkg::OpFetch, '0);
		add_req(srmq_pkg::OpFetch, '0);

		drain_then_set_capacity(5'd16);
		write_reg(srmq_pkg::CfgSortDesc, 5'd0);
		random_phase(280);

		drain_then_set_capacity(5'd0);
		write_reg(srmq_pkg::CfgSortDesc, 5'd1);
		send_idle_pct = 88;
		random_phase(150);

		drain_then_set_capacity(5'd31);
		send_idle_pct = 0;
		recv_stall_pct = 88;
		random_phase(300);

		drain_then_set_capacity(5'd5);
		write_reg(srmq_pkg::CfgSortDesc, 5'd0);
		send_idle_pct = 26;
		recv_stall_pct = 26;
		random_phase(300);

		drain_then_set_capacity(5'd1);
		write_reg(srmq_pkg::CfgSortDesc, 5'd1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_phase(150);

		drain_then_set_capacity(5'd2);
		write_reg(srmq_pkg::CfgSortDesc, 5'd0);
		send_idle_pct = 88;
		recv_stall_pct = 88;
		random_phase(150);

		drain_then_set_capacity(5'd12);
		write_reg(srmq_pkg::CfgSortDesc, 5'd1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_phase(300);

		drain_then_set_capacity(5'd16);
		write_reg(srmq_pkg::CfgSortDesc, 5'd0);
		send_idle_pct = 26;
		recv_stall_pct = 26;
		random_phase(300);

		wait_quiet();
		if (!failed) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#10ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
